@@ hw/rtl/sda_pkg.sv @@
// ============================================================================
// sda_pkg
// Shared types, widths and helper functions for the signed dihedral angle
// pipeline.
// ============================================================================
package sda_pkg;

    // Port field widths
    localparam int COORD_W    = 24;
    localparam int ANGLE_W    = 19;
    localparam int ANGLE_FRAC = 16;

    // Internal datapath widths
    localparam int DIFF_W   = COORD_W + 1;   // point difference
    localparam int VEC_B    = 24;            // difference magnitude bits after fit
    localparam int VEC_W    = VEC_B + 1;
    localparam int NRM_W    = 2 * VEC_W;     // cross product component
    localparam int NM_W     = NRM_W - 1;     // its magnitude
    localparam int NRM_B    = 30;            // normal magnitude bits after fit
    localparam int NRMS_W   = NRM_B + 1;
    localparam int PP_W     = 2 * NRMS_W;    // product of fitted normals
    localparam int XS_W     = 64;            // dot / cross sums
    localparam int MAG_W    = 62;            // their magnitudes
    localparam int PAIR_B   = 31;            // bits kept for the CORDIC pair
    localparam int SQ_W     = 64;            // sum of squares
    localparam int RT_W     = 32;            // its square root
    localparam int CD_W     = 36;            // CORDIC x / y
    localparam int Z_W      = 34;            // CORDIC angle, Q30
    localparam int ROOT_N   = 32;            // square root steps
    localparam int CORDIC_N = 31;            // CORDIC steps
    localparam int LO_SPLIT = 24;            // split point for the exact triple product
    localparam int NH_W     = NRM_W - LO_SPLIT;
    localparam int TH_W     = VEC_W + NH_W;
    localparam int TL_W     = VEC_W + LO_SPLIT + 1;
    localparam int HI_W     = TH_W + 2;
    localparam int LO_W     = TL_W + 2;
    localparam int TOT_W    = HI_W + LO_SPLIT + 1;

    localparam logic [Z_W-1:0] PI_Q30 = Z_W'(64'd3373259426);

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
        logic signed [COORD_W-1:0] d_x;
        logic signed [COORD_W-1:0] d_y;
        logic signed [COORD_W-1:0] d_z;
    } t_in_word;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] torsion_angle;
        logic                      degenerate;
    } t_out_word;

    // Position of the highest set bit plus one; zero for a zero word
    function automatic logic [6:0] bit_len(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

    // atan(2^-i) in Q30
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] a;
        unique case (i)
            0:       a = 32'd843314857;
            1:       a = 32'd497837829;
            2:       a = 32'd263043837;
            3:       a = 32'd133525159;
            4:       a = 32'd67021687;
            5:       a = 32'd33543516;
            6:       a = 32'd16775851;
            7:       a = 32'd8388437;
            8:       a = 32'd4194283;
            9:       a = 32'd2097149;
            default: a = 32'd1 << (30 - i);
        endcase
        return a;
    endfunction

endpackage

@@ hw/rtl/signed_dihedral_angle.sv @@
// ============================================================================
// signed_dihedral_angle
// Torsion angle of four points about the B-C axis, fully pipelined.
// ============================================================================
//
//  channel   direction  handshake                   word
//  -------   ---------  --------------------------  ------------------------
//  in        input      i_in_valid / o_in_ready     i_in_word  (t_in_word)
//  out       output     o_out_valid / i_out_ready   o_out_word (t_out_word)
//
//  One word enters per cycle while no word waits in the skid register; the
//  pipeline holds 13 front stages, 32 square root steps, 31 CORDIC steps,
//  one final stage, one output register. Root and CORDIC chains set the depth.
//  Reset clears only the valid bits; no state carries between words.
//  A skid register behind the output register takes one more word when the
//  output is held; the whole pipeline then holds until the skid drains.
//
module signed_dihedral_angle (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sda_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sda_pkg::t_out_word o_out_word
);
    import sda_pkg::*;

    localparam int FRONT_N = 13;
    localparam int NST     = FRONT_N + ROOT_N + CORDIC_N + 1;
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};
    localparam logic [Z_W-1:0] HALF = Z_W'(1) << (29 - ANGLE_FRAC);
    localparam logic [Z_W-1:0] LIM  = Z_W'((64'd1 << (ANGLE_W - 1)) - 64'd1);

    typedef struct packed {
        logic [PAIR_B-1:0] xs;
        logic              x_neg;
        logic              deg;
        logic              t_neg;
    } t_side;

    logic            en;
    logic            in_acc;
    logic [NST-1:0]  r_vld;
    logic            r_out_vld;
    logic            r_skid_vld;
    t_out_word       r_out;
    t_out_word       r_skid;
    t_out_word       s_fin;

    assign en          = !r_skid_vld;
    assign o_in_ready  = en;
    assign in_acc      = i_in_valid && en;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], in_acc};
        end
    end

    // ---------------------------------------------------------------- S1
    logic signed [COORD_W-1:0] s_p [4][3];
    logic signed [DIFF_W-1:0]  r1_d [3][3];

    always_comb begin
        s_p[0][0] = i_in_word.a_x; s_p[0][1] = i_in_word.a_y; s_p[0][2] = i_in_word.a_z;
        s_p[1][0] = i_in_word.b_x; s_p[1][1] = i_in_word.b_y; s_p[1][2] = i_in_word.b_z;
        s_p[2][0] = i_in_word.c_x; s_p[2][1] = i_in_word.c_y; s_p[2][2] = i_in_word.c_z;
        s_p[3][0] = i_in_word.d_x; s_p[3][1] = i_in_word.d_y; s_p[3][2] = i_in_word.d_z;
    end

    // ---------------------------------------------------------------- S2 fit
    logic [DIFF_W-1:0]        s1_mag [3][3];
    logic [DIFF_W-1:0]        s1_or  [3];
    logic [6:0]               s1_len [3];
    logic [DIFF_W-1:0]        s1_sh  [3][3];
    logic signed [VEC_W-1:0]  s2_d   [3][3];
    logic signed [VEC_W-1:0]  r2_d   [3][3];

    // scale each difference vector below 2^24 by a common shift
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s1_or[k] = '0;
            for (int j = 0; j < 3; j++) begin
                s1_mag[k][j] = r1_d[k][j][DIFF_W-1] ? DIFF_W'(-r1_d[k][j])
                                                    : DIFF_W'(r1_d[k][j]);
                s1_or[k] = s1_or[k] | s1_mag[k][j];
            end
            s1_len[k] = bit_len(64'(s1_or[k]));
            for (int j = 0; j < 3; j++) begin
                s1_sh[k][j] = (s1_len[k] > 7'(VEC_B)) ?
                              (s1_mag[k][j] >> (s1_len[k] - 7'(VEC_B))) : s1_mag[k][j];
                s2_d[k][j]  = r1_d[k][j][DIFF_W-1] ? -$signed(VEC_W'(s1_sh[k][j]))
                                                   : $signed(VEC_W'(s1_sh[k][j]));
            end
        end
    end

    // ---------------------------------------------------------------- S3..S4
    logic signed [NRM_W-1:0] r3_pa [3][2];
    logic signed [NRM_W-1:0] r3_pb [3][2];
    logic signed [VEC_W-1:0] r3_u  [3];
    logic signed [NRM_W-1:0] r4_n1 [3];
    logic signed [NRM_W-1:0] r4_n2 [3];
    logic signed [VEC_W-1:0] r4_u  [3];

    // ---------------------------------------------------------------- S5
    logic [NM_W-1:0]          s4_m1 [3];
    logic [NM_W-1:0]          s4_m2 [3];
    logic [NM_W-1:0]          s4_or1;
    logic [NM_W-1:0]          s4_or2;
    logic                     s4_deg;
    logic [NM_W-1:0]          r5_m1 [3];
    logic [NM_W-1:0]          r5_m2 [3];
    logic                     r5_s1 [3];
    logic                     r5_s2 [3];
    logic [6:0]               r5_len1;
    logic [6:0]               r5_len2;
    logic                     r5_deg;
    logic signed [TH_W-1:0]   r5_th [3];
    logic signed [TL_W-1:0]   r5_tl [3];

    always_comb begin
        s4_or1 = '0;
        s4_or2 = '0;
        for (int c = 0; c < 3; c++) begin
            s4_m1[c] = r4_n1[c][NRM_W-1] ? NM_W'(-r4_n1[c]) : NM_W'(r4_n1[c]);
            s4_m2[c] = r4_n2[c][NRM_W-1] ? NM_W'(-r4_n2[c]) : NM_W'(r4_n2[c]);
            s4_or1   = s4_or1 | s4_m1[c];
            s4_or2   = s4_or2 | s4_m2[c];
        end
        s4_deg = (s4_or1 == '0) || (s4_or2 == '0);
    end

    // ---------------------------------------------------------------- S6
    logic [NM_W-1:0]           s5_sh1 [3];
    logic [NM_W-1:0]           s5_sh2 [3];
    logic signed [NRMS_W-1:0]  s5_n1  [3];
    logic signed [NRMS_W-1:0]  s5_n2  [3];
    logic signed [NRMS_W-1:0]  r6_n1  [3];
    logic signed [NRMS_W-1:0]  r6_n2  [3];
    logic signed [HI_W-1:0]    r6_hi;
    logic signed [LO_W-1:0]    r6_lo;
    logic                      r6_deg;

    // bring each normal to a top magnitude in [2^29, 2^30)
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r5_len1 > 7'(NRM_B)) begin
                s5_sh1[c] = r5_m1[c] >> (r5_len1 - 7'(NRM_B));
            end else if (r5_len1 != '0) begin
                s5_sh1[c] = r5_m1[c] << (7'(NRM_B) - r5_len1);
            end else begin
                s5_sh1[c] = r5_m1[c];
            end
            if (r5_len2 > 7'(NRM_B)) begin
                s5_sh2[c] = r5_m2[c] >> (r5_len2 - 7'(NRM_B));
            end else if (r5_len2 != '0) begin
                s5_sh2[c] = r5_m2[c] << (7'(NRM_B) - r5_len2);
            end else begin
                s5_sh2[c] = r5_m2[c];
            end
            s5_n1[c] = r5_s1[c] ? -$signed({1'b0, s5_sh1[c][NRM_B-1:0]})
                                :  $signed({1'b0, s5_sh1[c][NRM_B-1:0]});
            s5_n2[c] = r5_s2[c] ? -$signed({1'b0, s5_sh2[c][NRM_B-1:0]})
                                :  $signed({1'b0, s5_sh2[c][NRM_B-1:0]});
        end
    end

    // ---------------------------------------------------------------- S7..S13
    logic signed [TOT_W-1:0] s6_tot;
    logic signed [PP_W-1:0]  r7_px [3];
    logic signed [PP_W-1:0]  r7_pm [3][2];
    logic                    r7_deg;
    logic                    r7_tneg;
    logic signed [XS_W-1:0]  r8_x;
    logic signed [XS_W-1:0]  r8_m [3];
    logic                    r8_deg;
    logic                    r8_tneg;
    logic [MAG_W-1:0]        r9_xm;
    logic [MAG_W-1:0]        r9_mm [3];
    logic                    r9_xneg;
    logic                    r9_deg;
    logic                    r9_tneg;
    logic [6:0]              s9_len;
    logic [MAG_W-1:0]        r10_xm;
    logic [MAG_W-1:0]        r10_mm [3];
    logic [5:0]              r10_s;
    logic                    r10_xneg;
    logic                    r10_deg;
    logic                    r10_tneg;
    logic [PAIR_B-1:0]       s10_xs;
    logic [PAIR_B-1:0]       r11_ms [3];
    t_side                   r11_side;
    logic [2*PAIR_B-1:0]     r12_sq [3];
    t_side                   r12_side;

    // exact triple product from its split partial sums
    assign s6_tot = (TOT_W'(r6_hi) <<< LO_SPLIT) + TOT_W'(r6_lo);

    assign s9_len = bit_len(64'(r9_xm | r9_mm[0] | r9_mm[1] | r9_mm[2]));
    assign s10_xs = PAIR_B'(r10_xm >> r10_s);

    always_ff @(posedge i_clk) begin
        if (en) begin
            // differences u = B - A, v = B - C, w = C - D
            for (int j = 0; j < 3; j++) begin
                r1_d[0][j] <= DIFF_W'(s_p[1][j]) - DIFF_W'(s_p[0][j]);
                r1_d[1][j] <= DIFF_W'(s_p[1][j]) - DIFF_W'(s_p[2][j]);
                r1_d[2][j] <= DIFF_W'(s_p[2][j]) - DIFF_W'(s_p[3][j]);
            end
            r2_d <= s2_d;
            // cross product terms of u x v and v x w
            for (int c = 0; c < 3; c++) begin
                r3_pa[c][0] <= r2_d[0][NXT[c]] * r2_d[1][PRV[c]];
                r3_pa[c][1] <= r2_d[0][PRV[c]] * r2_d[1][NXT[c]];
                r3_pb[c][0] <= r2_d[1][NXT[c]] * r2_d[2][PRV[c]];
                r3_pb[c][1] <= r2_d[1][PRV[c]] * r2_d[2][NXT[c]];
                r3_u[c]     <= r2_d[0][c];
            end
            for (int c = 0; c < 3; c++) begin
                r4_n1[c] <= r3_pa[c][0] - r3_pa[c][1];
                r4_n2[c] <= r3_pb[c][0] - r3_pb[c][1];
                r4_u[c]  <= r3_u[c];
            end
            // normal magnitudes and triple product partial products
            for (int c = 0; c < 3; c++) begin
                r5_m1[c] <= s4_m1[c];
                r5_m2[c] <= s4_m2[c];
                r5_s1[c] <= r4_n1[c][NRM_W-1];
                r5_s2[c] <= r4_n2[c][NRM_W-1];
                r5_th[c] <= r4_u[c] * $signed(r4_n2[c][NRM_W-1:LO_SPLIT]);
                r5_tl[c] <= r4_u[c] * $signed({1'b0, r4_n2[c][LO_SPLIT-1:0]});
            end
            r5_len1 <= bit_len(64'(s4_or1));
            r5_len2 <= bit_len(64'(s4_or2));
            r5_deg  <= s4_deg;
            r6_n1   <= s5_n1;
            r6_n2   <= s5_n2;
            r6_hi   <= HI_W'(r5_th[0]) + HI_W'(r5_th[1]) + HI_W'(r5_th[2]);
            r6_lo   <= LO_W'(r5_tl[0]) + LO_W'(r5_tl[1]) + LO_W'(r5_tl[2]);
            r6_deg  <= r5_deg;
            // dot and cross of the fitted normals
            for (int c = 0; c < 3; c++) begin
                r7_px[c]    <= r6_n1[c] * r6_n2[c];
                r7_pm[c][0] <= r6_n1[NXT[c]] * r6_n2[PRV[c]];
                r7_pm[c][1] <= r6_n1[PRV[c]] * r6_n2[NXT[c]];
            end
            r7_deg  <= r6_deg;
            r7_tneg <= s6_tot[TOT_W-1];
            r8_x    <= XS_W'(r7_px[0]) + XS_W'(r7_px[1]) + XS_W'(r7_px[2]);
            for (int c = 0; c < 3; c++) begin
                r8_m[c] <= XS_W'(r7_pm[c][0]) - XS_W'(r7_pm[c][1]);
            end
            r8_deg  <= r7_deg;
            r8_tneg <= r7_tneg;
            // magnitudes
            r9_xm   <= r8_x[XS_W-1] ? MAG_W'(-r8_x) : MAG_W'(r8_x);
            for (int c = 0; c < 3; c++) begin
                r9_mm[c] <= r8_m[c][XS_W-1] ? MAG_W'(-r8_m[c]) : MAG_W'(r8_m[c]);
            end
            r9_xneg <= r8_x[XS_W-1];
            r9_deg  <= r8_deg;
            r9_tneg <= r8_tneg;
            // common shift that brings the pair below 2^31
            r10_xm   <= r9_xm;
            r10_mm   <= r9_mm;
            r10_s    <= (s9_len > 7'(PAIR_B)) ? 6'(s9_len - 7'(PAIR_B)) : '0;
            r10_xneg <= r9_xneg;
            r10_deg  <= r9_deg;
            r10_tneg <= r9_tneg;
            for (int c = 0; c < 3; c++) begin
                r11_ms[c] <= PAIR_B'(r10_mm[c] >> r10_s);
            end
            r11_side.xs    <= s10_xs;
            r11_side.x_neg <= r10_xneg && (s10_xs != '0);
            r11_side.deg   <= r10_deg;
            r11_side.t_neg <= r10_tneg;
            for (int c = 0; c < 3; c++) begin
                r12_sq[c] <= r11_ms[c] * r11_ms[c];
            end
            r12_side <= r11_side;
        end
    end

    // ---------------------------------------------------------------- root
    logic [SQ_W-1:0] r_rq    [ROOT_N+1];
    logic [SQ_W-1:0] r_rr    [ROOT_N+1];
    t_side           r_rside [ROOT_N+1];
    logic [SQ_W-1:0] s_rbit  [ROOT_N];
    logic [SQ_W-1:0] s_rtry  [ROOT_N];

    always_comb begin
        for (int k = 0; k < ROOT_N; k++) begin
            s_rbit[k] = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            s_rtry[k] = r_rr[k] + s_rbit[k];
        end
    end

    // one result bit per stage, restoring square root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rq[0]    <= SQ_W'(r12_sq[0]) + SQ_W'(r12_sq[1]) + SQ_W'(r12_sq[2]);
            r_rr[0]    <= '0;
            r_rside[0] <= r12_side;
            for (int k = 0; k < ROOT_N; k++) begin
                if (r_rq[k] >= s_rtry[k]) begin
                    r_rq[k+1] <= r_rq[k] - s_rtry[k];
                    r_rr[k+1] <= (r_rr[k] >> 1) + s_rbit[k];
                end else begin
                    r_rq[k+1] <= r_rq[k];
                    r_rr[k+1] <= r_rr[k] >> 1;
                end
                r_rside[k+1] <= r_rside[k];
            end
        end
    end

    // ---------------------------------------------------------------- CORDIC
    logic signed [CD_W-1:0] s_cx [CORDIC_N];
    logic signed [CD_W-1:0] s_cy [CORDIC_N];
    logic signed [Z_W-1:0]  s_cz [CORDIC_N];
    t_side                  s_cs [CORDIC_N];
    logic signed [CD_W-1:0] s_dx [CORDIC_N];
    logic signed [CD_W-1:0] s_dy [CORDIC_N];
    logic signed [Z_W-1:0]  s_ca [CORDIC_N];
    logic signed [CD_W-1:0] r_cx [1:CORDIC_N];
    logic signed [CD_W-1:0] r_cy [1:CORDIC_N];
    logic signed [Z_W-1:0]  r_cz [1:CORDIC_N];
    t_side                  r_cs [1:CORDIC_N];

    always_comb begin
        s_cx[0] = $signed({{(CD_W-PAIR_B){1'b0}}, r_rside[ROOT_N].xs});
        s_cy[0] = $signed({{(CD_W-RT_W){1'b0}}, r_rr[ROOT_N][RT_W-1:0]});
        s_cz[0] = '0;
        s_cs[0] = r_rside[ROOT_N];
        for (int i = 1; i < CORDIC_N; i++) begin
            s_cx[i] = r_cx[i];
            s_cy[i] = r_cy[i];
            s_cz[i] = r_cz[i];
            s_cs[i] = r_cs[i];
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            s_dx[i] = s_cx[i] >>> i;
            s_dy[i] = s_cy[i] >>> i;
            s_ca[i] = $signed(Z_W'(atan_q30(i)));
        end
    end

    // vectoring: rotate y toward zero, accumulate the angle
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < CORDIC_N; i++) begin
                if (!s_cy[i][CD_W-1]) begin
                    r_cx[i+1] <= s_cx[i] + s_dy[i];
                    r_cy[i+1] <= s_cy[i] - s_dx[i];
                    r_cz[i+1] <= s_cz[i] + s_ca[i];
                end else begin
                    r_cx[i+1] <= s_cx[i] - s_dy[i];
                    r_cy[i+1] <= s_cy[i] + s_dx[i];
                    r_cz[i+1] <= s_cz[i] - s_ca[i];
                end
                r_cs[i+1] <= s_cs[i];
            end
        end
    end

    // ---------------------------------------------------------------- final
    logic signed [Z_W:0]  s_fz;
    logic [Z_W-1:0]       r_fz;
    t_side                r_fside;
    logic [Z_W-1:0]       s_rnd;
    logic [Z_W-1:0]       s_ang;
    logic [Z_W-1:0]       s_sat;

    // fold into [0, pi] for a negative dot product, then clamp
    always_comb begin
        if (r_cs[CORDIC_N].x_neg) begin
            s_fz = $signed({1'b0, PI_Q30}) - (Z_W+1)'(r_cz[CORDIC_N]);
        end else begin
            s_fz = (Z_W+1)'(r_cz[CORDIC_N]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (s_fz[Z_W]) begin
                r_fz <= '0;
            end else if (s_fz > $signed({1'b0, PI_Q30})) begin
                r_fz <= PI_Q30;
            end else begin
                r_fz <= s_fz[Z_W-1:0];
            end
            r_fside <= r_cs[CORDIC_N];
        end
    end

    // round to the output fraction, sign, saturate; degenerate words carry zero
    always_comb begin
        s_rnd = r_fz + HALF;
        s_ang = s_rnd >> (30 - ANGLE_FRAC);
        s_sat = (s_ang > LIM) ? LIM : s_ang;
        if (r_fside.deg) begin
            s_fin.torsion_angle = '0;
            s_fin.degenerate    = 1'b1;
        end else begin
            s_fin.torsion_angle = r_fside.t_neg ? -$signed(s_sat[ANGLE_W-1:0])
                                                :  $signed(s_sat[ANGLE_W-1:0]);
            s_fin.degenerate    = 1'b0;
        end
    end

    // ---------------------------------------------------------------- output
    // drain the skid first; otherwise load the output or park in the skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_out_ready) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[NST-1]) begin
            if (!r_out_vld || i_out_ready) begin
                r_out     <= s_fin;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= s_fin;
                r_skid_vld <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

endmodule

@@ hw/rtl/sda_chk.sv @@
// ============================================================================
// sda_chk
// Port-level checks for the signed dihedral angle block, bound to its top.
// ============================================================================
module sda_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input sda_pkg::t_out_word o_out_word
);
    import sda_pkg::*;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    // hold a word that is not taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // degenerate geometry carries a zero angle
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.degenerate |-> o_out_word.torsion_angle == '0)
        else $error("degenerate word with nonzero angle");

    // saturation is symmetric
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.torsion_angle != ANGLE_MIN)
        else $error("angle at the negative limit");

    // input stalls only behind a held output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no output pending");

    // reset empties the output side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("not empty after reset");

endmodule

bind signed_dihedral_angle sda_chk u_sda_chk (.*);

@@ tb/sv/signed_dihedral_angle_checker.sv @@
// ----------------------------------------------------------------------------
// signed_dihedral_angle_checker
// Watches both channels of the torsion angle block, predicts each result word
// from the accepted input word and compares the two field by field in order.
// ----------------------------------------------------------------------------
module signed_dihedral_angle_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  sda_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  sda_pkg::t_out_word i_out_word,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sda_pkg::*;

    localparam longint PI_Z = 64'sd3373259426;

    t_out_word angle_queue[$];

    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic int width_of(input longint v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    // Scale a vector so its largest magnitude has at most the given bit count (exactly that count when grow is set)
    function automatic void scale_vec(inout longint v[3], input int bits, input bit grow);
        longint big;
        int     len;
        big = 0;
        for (int i = 0; i < 3; i++) if (mag_of(v[i]) > big) big = mag_of(v[i]);
        len = width_of(big);
        if (len > bits) begin
            for (int i = 0; i < 3; i++)
                v[i] = (v[i] < 0) ? -(mag_of(v[i]) >> (len - bits)) : (v[i] >> (len - bits));
        end else if (grow && len > 0 && len < bits) begin
            for (int i = 0; i < 3; i++) v[i] = v[i] <<< (bits - len);
        end
    endfunction

    function automatic void cross_of(input longint p[3], input longint q[3],
                                     output longint r[3]);
        r[0] = p[1] * q[2] - p[2] * q[1];
        r[1] = q[0] * p[2] - p[0] * q[2];
        r[2] = p[0] * q[1] - q[0] * p[1];
    endfunction

    function automatic int orient_sign(input longint u[3], input longint n[3]);
        logic signed [127:0] acc;
        acc = 0;
        for (int i = 0; i < 3; i++) acc += 128'(u[i]) * 128'(n[i]);
        return (acc > 0) ? 1 : ((acc < 0) ? -1 : 0);
    endfunction

    function automatic longint root_floor(input logic [63:0] q);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > q) bitv >>= 2;
        while (bitv != 0) begin
            if (q >= res + bitv) begin
                q -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_step(input int i);
        longint tab[10];
        tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                33543516, 16775851, 8388437, 4194283, 2097149};
        return (i < 10) ? tab[i] : (64'sd1 <<< (30 - i));
    endfunction

    function automatic longint vector_angle(input longint x, input longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < 31; i++) begin
            dx = floor_shr(x, i);
            dy = floor_shr(y, i);
            if (y >= 0) begin
                x += dy; y -= dx; z += atan_step(i);
            end else begin
                x -= dy; y += dx; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic t_out_word torsion_of(input t_in_word w);
        longint    u[3], v[3], d[3], n1[3], n2[3], m[3];
        longint    x, y, z, ang, big, mm;
        logic [63:0] sq;
        int        len, s, sg;
        t_out_word r;
        u[0] = longint'(w.b_x) - longint'(w.a_x);
        u[1] = longint'(w.b_y) - longint'(w.a_y);
        u[2] = longint'(w.b_z) - longint'(w.a_z);
        v[0] = longint'(w.b_x) - longint'(w.c_x);
        v[1] = longint'(w.b_y) - longint'(w.c_y);
        v[2] = longint'(w.b_z) - longint'(w.c_z);
        d[0] = longint'(w.c_x) - longint'(w.d_x);
        d[1] = longint'(w.c_y) - longint'(w.d_y);
        d[2] = longint'(w.c_z) - longint'(w.d_z);
        scale_vec(u, 24, 0);
        scale_vec(v, 24, 0);
        scale_vec(d, 24, 0);
        cross_of(u, v, n1);
        cross_of(v, d, n2);
        r.torsion_angle = '0;
        r.degenerate = 1'b1;
        if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
            (n2[0] == 0 && n2[1] == 0 && n2[2] == 0)) return r;
        sg = orient_sign(u, n2);
        scale_vec(n1, 30, 1);
        scale_vec(n2, 30, 1);
        x = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
        cross_of(n1, n2, m);
        big = mag_of(x);
        for (int j = 0; j < 3; j++) if (mag_of(m[j]) > big) big = mag_of(m[j]);
        len = width_of(big);
        s = (len > 31) ? len - 31 : 0;
        x = (x < 0) ? -(mag_of(x) >> s) : (x >> s);
        sq = 0;
        for (int j = 0; j < 3; j++) begin
            mm = mag_of(m[j]) >> s;
            sq += 64'(mm * mm);
        end
        y = root_floor(sq);
        z = (x < 0) ? PI_Z - vector_angle(-x, y) : vector_angle(x, y);
        if (z < 0) z = 0;
        if (z > PI_Z) z = PI_Z;
        ang = (z + (64'sd1 <<< (29 - ANGLE_FRAC))) >>> (30 - ANGLE_FRAC);
        if (sg < 0) ang = -ang;
        if (ang > 262143) ang = 262143;
        if (ang < -262143) ang = -262143;
        r.torsion_angle = ANGLE_W'(ang);
        r.degenerate = 1'b0;
        return r;
    endfunction

    assign o_pending = angle_queue.size();

    // Predict on input words, compare on output words
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) angle_queue.push_back(torsion_of(i_in_word));
            if (i_out_valid && i_out_ready) begin
                if (angle_queue.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected word %p", i_out_word);
                end else begin
                    want = angle_queue.pop_front();
                    if (want.torsion_angle !== i_out_word.torsion_angle ||
                        want.degenerate !== i_out_word.degenerate) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: expected angle %0d degen %0b, got %0d %0b",
                                     want.torsion_angle, want.degenerate,
                                     i_out_word.torsion_angle, i_out_word.degenerate);
                    end
                end
            end
        end
    end
endmodule

@@ tb/sv/signed_dihedral_angle_test.sv @@
// ----------------------------------------------------------------------------
// signed_dihedral_angle_test
// Drives point quadruples into the torsion angle block with random gaps and
// output stalls; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module signed_dihedral_angle_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sda_pkg::*;

    localparam int RANDOM_WORDS = 1250;
    localparam int LATENCY      = 80;

    logic      i_clk, i_rst_n, i_in_valid, i_out_ready;
    logic      o_in_ready, o_out_valid;
    t_in_word  i_in_word;
    t_out_word o_out_word;
    int        errors, pending;
    bit        calm;

    signed_dihedral_angle uut (.*);

    signed_dihedral_angle_checker chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_in_word,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_word(o_out_word),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("signed_dihedral_angle_test: done, errors");
        $finish;
    end

    // Stall the output about a third of the time, except in the calm stretch
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 33);
    end

    function automatic logic [23:0] rand_coord(input int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(8192)) - 4096);
            default: return ($urandom_range(1)) ? 24'h7fffff : 24'h800000;
        endcase
    endfunction

    // Idle at random, then hand one word over and hold it until accepted
    task automatic send_word(input t_in_word w);
        while (!calm && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic t_in_word make_pts(input int mode);
        t_in_word w;
        int base;
        w = {12{rand_coord(mode)}};
        w.a_x = rand_coord(mode); w.a_y = rand_coord(mode); w.a_z = rand_coord(mode);
        w.b_x = rand_coord(mode); w.b_y = rand_coord(mode); w.b_z = rand_coord(mode);
        w.c_x = rand_coord(mode); w.c_y = rand_coord(mode); w.c_z = rand_coord(mode);
        w.d_x = rand_coord(mode); w.d_y = rand_coord(mode); w.d_z = rand_coord(mode);
        base = $urandom_range(9);
        // Make some collinear or coplanar sets
        if (base == 0) w.c_x = w.b_x;
        if (base == 1) {w.c_x, w.c_y, w.c_z} = {w.b_x, w.b_y, w.b_z};
        if (base == 2) {w.d_x, w.d_y, w.d_z} = {w.a_x, w.a_y, w.a_z};
        if (base == 3) w.d_z = w.a_z;
        return w;
    endfunction

    function automatic t_in_word quad(input int ax, ay, az, bx, by, bz,
                                      cx, cy, cz, dx, dy, dz);
        return {24'(ax), 24'(ay), 24'(az), 24'(bx), 24'(by), 24'(bz),
                24'(cx), 24'(cy), 24'(cz), 24'(dx), 24'(dy), 24'(dz)};
    endfunction

    initial begin
        i_rst_n = 0; i_in_valid = 0; i_out_ready = 0; i_in_word = '0;
        calm = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: trans, cis, +/-90, coplanar, degenerate, extremes
        send_word(quad(4096, 0, 0, 0, 0, 0, 0, 4096, 0, -4096, 4096, 0));
        send_word(quad(4096, 0, 0, 0, 0, 0, 0, 4096, 0, 4096, 4096, 0));
        send_word(quad(4096, 0, 0, 0, 0, 0, 0, 4096, 0, 0, 4096, 4096));
        send_word(quad(4096, 0, 0, 0, 0, 0, 0, 4096, 0, 0, 4096, -4096));
        send_word(quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(quad(0, 0, 0, 4096, 0, 0, 8192, 0, 0, 0, 4096, 0));
        send_word(quad(1, 2, 3, 1, 2, 3, 5, 6, 7, 8, 9, 1));
        send_word(quad(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                       -8388608, 8388607, -8388608, 8388607, -8388608, 8388607));
        send_word(quad(8388607, -8388608, 0, -8388608, 8388607, 0,
                       8388607, 8388607, -8388608, -8388608, -8388608, 8388607));
        send_word(quad(1, 0, 0, 0, 0, 0, 0, 1, 0, -1, 1, 1));
        send_word(quad(-1, -1, -1, 0, 0, 0, 1, 0, 0, 1, 1, -1));
        send_word({12{24'h555555}} ^ {12{24'h000fff}});
        for (int i = 0; i < 6; i++) send_word(make_pts(2));
        // Drain fully once before the random part
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (LATENCY) @(posedge i_clk);
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= 400 && i < 550);
            send_word(make_pts($urandom_range(2)));
        end
        calm = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (LATENCY) @(posedge i_clk);
        if (errors == 0) begin
            $display("signed_dihedral_angle_test: done, clean");
        end else begin
            $display("signed_dihedral_angle_test: done, errors");
        end
        $finish;
    end
endmodule
